/* design/nps_pkg.sv */
// ----------------------------------------------------------------------------
// nps_pkg
// Shared sizes, word layouts and the request that the sequencer sends to the
// job store of the non-preemptive priority scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package nps_pkg;

  localparam int MAX_JOBS = 16;
  localparam int IDX_W    = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int CNT_W    = $clog2(MAX_JOBS + 1);
  localparam int ID_W     = 8;
  localparam int TIME_W   = 12;
  localparam int PRI_W    = 8;
  localparam int COMP_W   = 17;
  localparam int SUM_W    = 21;
  localparam int KEY_W    = ID_W + IDX_W;

  typedef struct packed {
    logic [ID_W-1:0]   job_id;
    logic [TIME_W-1:0] arrival;
    logic [TIME_W-1:0] burst;
    logic [PRI_W-1:0]  priority_req;
    logic              last_job;
  } in_word_t;

  typedef struct packed {
    logic [ID_W-1:0]   out_id;
    logic [TIME_W-1:0] out_arrival;
    logic [TIME_W-1:0] out_burst;
    logic [PRI_W-1:0]  out_priority;
    logic [COMP_W-1:0] completion;
    logic [COMP_W-1:0] turnaround;
    logic [COMP_W-1:0] waiting;
    logic [SUM_W-1:0]  total_waiting;
    logic [SUM_W-1:0]  total_turnaround;
    logic              last_result;
  } out_word_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] arr;
    logic [TIME_W-1:0] len;
    logic [PRI_W-1:0]  pri;
  } job_t;

  typedef struct packed {
    logic              load_en;
    logic [IDX_W-1:0]  load_idx;
    job_t              load_job;
    logic              done_en;
    logic [IDX_W-1:0]  done_idx;
    logic [COMP_W-1:0] done_time;
    logic              clear_done;
    logic [IDX_W-1:0]  rd_idx;
  } store_req_t;

endpackage

`default_nettype wire

/* design/nps_job_store.sv */
// ----------------------------------------------------------------------------
// nps_job_store
// Job table, finished flags and completion times, with one read port that
// the sequencer steers.
// ----------------------------------------------------------------------------
`default_nettype none

module nps_job_store
  import nps_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire store_req_t        req,
  output job_t                   rd_job,
  output logic                   rd_done,
  output logic [COMP_W-1:0]      rd_comp
);

  job_t                jobs_r [MAX_JOBS];
  logic [COMP_W-1:0]   comp_r [MAX_JOBS];
  logic [MAX_JOBS-1:0] done_r;

  always_ff @(posedge clk) begin
    if (req.load_en) begin
      jobs_r[req.load_idx] <= req.load_job;
    end
    if (req.done_en) begin
      comp_r[req.done_idx] <= req.done_time;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= '0;
    end else if (req.clear_done) begin
      done_r <= '0;
    end else begin
      if (req.load_en) begin
        done_r[req.load_idx] <= 1'b0;
      end
      if (req.done_en) begin
        done_r[req.done_idx] <= 1'b1;
      end
    end
  end

  assign rd_job  = jobs_r[req.rd_idx];
  assign rd_done = done_r[req.rd_idx];
  assign rd_comp = comp_r[req.rd_idx];

endmodule

`default_nettype wire

/* design/nps_sched_ctrl.sv */
// ----------------------------------------------------------------------------
// nps_sched_ctrl
// Sequencer: loads jobs, scans the table once per decision with one compare
// unit, then scans again per result to emit jobs in ascending id order.
// ----------------------------------------------------------------------------
`default_nettype none

module nps_sched_ctrl
  import nps_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire in_word_t          in_word,
  output store_req_t             req,
  input  wire job_t              rd_job,
  input  wire logic              rd_done,
  input  wire logic [COMP_W-1:0] rd_comp,
  output logic                   res_valid,
  output out_word_t              res,
  input  wire logic              slot_free
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SCAN   = 6'b000010,
    S_APPLY  = 6'b000100,
    S_SORT   = 6'b001000,
    S_CALC_T = 6'b010000,
    S_EMIT   = 6'b100000
  } state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  finished_r, finished_nxt;
  logic [CNT_W-1:0]  emitted_r, emitted_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [COMP_W-1:0] clock_r, clock_nxt;
  logic              any_r, any_nxt;
  logic              have_r, have_nxt;
  logic              have_prev_r, have_prev_nxt;
  logic              calc_w_r, calc_w_nxt;

  logic [TIME_W-1:0] earliest_r, earliest_nxt;
  logic [IDX_W-1:0]  best_idx_r, best_idx_nxt;
  logic [PRI_W-1:0]  best_pri_r, best_pri_nxt;
  logic [TIME_W-1:0] best_arr_r, best_arr_nxt;
  logic [TIME_W-1:0] best_len_r, best_len_nxt;
  logic [KEY_W-1:0]  best_key_r, best_key_nxt;
  logic [KEY_W-1:0]  prev_key_r, prev_key_nxt;
  logic [COMP_W-1:0] turn_r, turn_nxt;
  logic [COMP_W-1:0] wait_r, wait_nxt;
  logic [SUM_W-1:0]  sum_wait_r, sum_wait_nxt;
  logic [SUM_W-1:0]  sum_turn_r, sum_turn_nxt;

  logic              scan_end;
  logic              is_last;
  logic [KEY_W-1:0]  cur_key;
  logic [SUM_W-1:0]  sum_wait_new;

  assign scan_end     = (CNT_W'(idx_r) + CNT_W'(1)) == count_r;
  assign is_last      = (emitted_r + CNT_W'(1)) == count_r;
  assign cur_key      = {rd_job.id, idx_r};
  assign sum_wait_new = sum_wait_r + SUM_W'(wait_r);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    finished_nxt  = finished_r;
    emitted_nxt   = emitted_r;
    idx_nxt       = idx_r;
    clock_nxt     = clock_r;
    any_nxt       = any_r;
    have_nxt      = have_r;
    have_prev_nxt = have_prev_r;
    calc_w_nxt    = calc_w_r;
    earliest_nxt  = earliest_r;
    best_idx_nxt  = best_idx_r;
    best_pri_nxt  = best_pri_r;
    best_arr_nxt  = best_arr_r;
    best_len_nxt  = best_len_r;
    best_key_nxt  = best_key_r;
    prev_key_nxt  = prev_key_r;
    turn_nxt      = turn_r;
    wait_nxt      = wait_r;
    sum_wait_nxt  = sum_wait_r;
    sum_turn_nxt  = sum_turn_r;
    req           = '0;
    req.rd_idx    = idx_r;
    in_stall      = 1'b1;
    res_valid     = 1'b0;
    res           = '0;

    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (count_r < CNT_W'(MAX_JOBS)) begin
            req.load_en      = 1'b1;
            req.load_idx     = count_r[IDX_W-1:0];
            req.load_job.id  = in_word.job_id;
            req.load_job.arr = in_word.arrival;
            req.load_job.len = in_word.burst;
            req.load_job.pri = in_word.priority_req;
            count_nxt        = count_r + CNT_W'(1);
          end
          if (in_word.last_job) begin
            state_nxt    = S_SCAN;
            clock_nxt    = '0;
            finished_nxt = '0;
            idx_nxt      = '0;
            have_nxt     = 1'b0;
            any_nxt      = 1'b0;
          end
        end
      end
      S_SCAN: begin
        if (!rd_done) begin
          any_nxt = 1'b1;
          if (!any_r || rd_job.arr < earliest_r) begin
            earliest_nxt = rd_job.arr;
          end
          if (COMP_W'(rd_job.arr) <= clock_r &&
              (!have_r || rd_job.pri > best_pri_r ||
               (rd_job.pri == best_pri_r && rd_job.arr < best_arr_r))) begin
            have_nxt     = 1'b1;
            best_idx_nxt = idx_r;
            best_pri_nxt = rd_job.pri;
            best_arr_nxt = rd_job.arr;
            best_len_nxt = rd_job.len;
          end
        end
        if (scan_end) begin
          state_nxt = S_APPLY;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      S_APPLY: begin
        idx_nxt   = '0;
        have_nxt  = 1'b0;
        any_nxt   = 1'b0;
        state_nxt = S_SCAN;
        if (have_r) begin
          clock_nxt     = clock_r + COMP_W'(best_len_r);
          req.done_en   = 1'b1;
          req.done_idx  = best_idx_r;
          req.done_time = clock_nxt;
          finished_nxt  = finished_r + CNT_W'(1);
          if (finished_nxt == count_r) begin
            state_nxt     = S_SORT;
            have_prev_nxt = 1'b0;
            emitted_nxt   = '0;
            sum_wait_nxt  = '0;
            sum_turn_nxt  = '0;
          end
        end else begin
          clock_nxt = COMP_W'(earliest_r);
        end
      end
      S_SORT: begin
        if ((!have_prev_r || cur_key > prev_key_r) &&
            (!have_r || cur_key < best_key_r)) begin
          have_nxt     = 1'b1;
          best_key_nxt = cur_key;
          best_idx_nxt = idx_r;
        end
        if (scan_end) begin
          state_nxt  = S_CALC_T;
          calc_w_nxt = 1'b0;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      S_CALC_T: begin
        req.rd_idx = best_idx_r;
        if (!calc_w_r) begin
          turn_nxt   = rd_comp - COMP_W'(rd_job.arr);
          calc_w_nxt = 1'b1;
        end else begin
          wait_nxt     = turn_r - COMP_W'(rd_job.len);
          sum_turn_nxt = sum_turn_r + SUM_W'(turn_r);
          state_nxt    = S_EMIT;
        end
      end
      S_EMIT: begin
        req.rd_idx           = best_idx_r;
        res_valid            = 1'b1;
        res.out_id           = rd_job.id;
        res.out_arrival      = rd_job.arr;
        res.out_burst        = rd_job.len;
        res.out_priority     = rd_job.pri;
        res.completion       = rd_comp;
        res.turnaround       = turn_r;
        res.waiting          = wait_r;
        res.total_waiting    = is_last ? sum_wait_new : '0;
        res.total_turnaround = is_last ? sum_turn_r : '0;
        res.last_result      = is_last;
        if (slot_free) begin
          sum_wait_nxt  = sum_wait_new;
          prev_key_nxt  = best_key_r;
          have_prev_nxt = 1'b1;
          emitted_nxt   = emitted_r + CNT_W'(1);
          idx_nxt       = '0;
          have_nxt      = 1'b0;
          if (is_last) begin
            state_nxt      = S_IDLE;
            count_nxt      = '0;
            clock_nxt      = '0;
            req.clear_done = 1'b1;
          end else begin
            state_nxt = S_SORT;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      finished_r  <= '0;
      emitted_r   <= '0;
      idx_r       <= '0;
      clock_r     <= '0;
      any_r       <= 1'b0;
      have_r      <= 1'b0;
      have_prev_r <= 1'b0;
      calc_w_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      finished_r  <= finished_nxt;
      emitted_r   <= emitted_nxt;
      idx_r       <= idx_nxt;
      clock_r     <= clock_nxt;
      any_r       <= any_nxt;
      have_r      <= have_nxt;
      have_prev_r <= have_prev_nxt;
      calc_w_r    <= calc_w_nxt;
    end
  end

  always_ff @(posedge clk) begin
    earliest_r <= earliest_nxt;
    best_idx_r <= best_idx_nxt;
    best_pri_r <= best_pri_nxt;
    best_arr_r <= best_arr_nxt;
    best_len_r <= best_len_nxt;
    best_key_r <= best_key_nxt;
    prev_key_r <= prev_key_nxt;
    turn_r     <= turn_nxt;
    wait_r     <= wait_nxt;
    sum_wait_r <= sum_wait_nxt;
    sum_turn_r <= sum_turn_nxt;
  end

`ifndef SYNTH
  a_scan_has_jobs: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (count_r != '0))
    else $error("scan started with an empty job table");

  a_apply_unfinished: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_APPLY) |-> (finished_r < count_r))
    else $error("decision taken after all jobs finished");

  a_calc_has_pick: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CALC_T) |-> have_r)
    else $error("result pass found no job to report");

  a_last_word_ends_set: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && slot_free && is_last) |=>
      (state_r == S_IDLE && count_r == '0 && clock_r == '0))
    else $error("set not cleared after final result word");
`endif

endmodule

`default_nettype wire

/* design/nonpreemptive_priority_scheduler.sv */
// ----------------------------------------------------------------------------
// nonpreemptive_priority_scheduler
// Loads up to MAX_JOBS jobs, schedules them non-preemptively by priority,
// and reports each job's completion, turnaround and waiting times.
//
// Usage: send one job per word on in_valid/in_stall/in_word. Each word is
// stored unless the table is full, in which case it is dropped. A word with
// last_job (stored too, on the same terms) starts scheduling; in_stall
// stays high until the last result word has been handed to the output register.
// Scheduling with n jobs takes n decisions, each a scan of the table and an
// apply step, plus one extra pass for each gap in which no job has arrived.
// Reporting then takes, per result word, an id-order scan of the table, two
// subtract steps and the hand-off to the output register. Results come out
// in ascending job id (equal ids in load order) on out_valid/out_stall/
// out_word; the last word carries last_result and the set totals.
// A stalled out_word holds; the sequencer waits in its hand-off step.
// Reset clears the job count, the finished flags and out_valid.
// ----------------------------------------------------------------------------
`default_nettype none

module nonpreemptive_priority_scheduler
  import nps_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_word_t  in_word,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_word_t      out_word
);

  store_req_t        req;
  job_t              rd_job;
  logic              rd_done;
  logic [COMP_W-1:0] rd_comp;
  logic              res_valid;
  out_word_t         res;
  logic              slot_free;
  logic              out_valid_r;
  out_word_t         out_word_r;

  nps_job_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (req),
    .rd_job  (rd_job),
    .rd_done (rd_done),
    .rd_comp (rd_comp)
  );

  nps_sched_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .req       (req),
    .rd_job    (rd_job),
    .rd_done   (rd_done),
    .rd_comp   (rd_comp),
    .res_valid (res_valid),
    .res       (res),
    .slot_free (slot_free)
  );

  assign slot_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && slot_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && slot_free) begin
      out_word_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

`default_nettype wire
